FILE: rtl/eli_pkg.sv
// Shared constants, angle table and state type for the encoder length interpolator.
`timescale 1ns / 1ps

package eli_pkg;

    // Default table shape
    localparam int ELI_POINTS_DEF = 39;
    localparam int ELI_STEP_DEF   = 2000;

    // Divisor width of the shared divider (twice a 16-bit segment span)
    localparam int ELI_DVS_W = 17;

    // Configuration port
    localparam int                  ELI_ADDR_W    = 3;
    localparam logic [ELI_ADDR_W-1:0] ELI_ADDR_GEAR = 3'd0;
    localparam logic [7:0]          ELI_GEAR_RST  = 8'd70;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GDIV0,
        ST_GDIV,
        ST_CHK,
        ST_SCAN,
        ST_MUL,
        ST_SDIV,
        ST_SCL,
        ST_DONE
    } t_eli_state;

    // Angle at each table point; unused points read as zero
    function automatic logic [15:0] eli_angle(input logic [5:0] idx);
        logic [15:0] a;
        case (idx)
            6'd0:  a = 16'd628;
            6'd1:  a = 16'd887;
            6'd2:  a = 16'd1117;
            6'd3:  a = 16'd1564;
            6'd4:  a = 16'd1840;
            6'd5:  a = 16'd2200;
            6'd6:  a = 16'd2534;
            6'd7:  a = 16'd2797;
            6'd8:  a = 16'd3064;
            6'd9:  a = 16'd3409;
            6'd10: a = 16'd3649;
            6'd11: a = 16'd3904;
            6'd12: a = 16'd4209;
            6'd13: a = 16'd4533;
            6'd14: a = 16'd4755;
            6'd15: a = 16'd5042;
            6'd16: a = 16'd5320;
            6'd17: a = 16'd5656;
            6'd18: a = 16'd5899;
            6'd19: a = 16'd6304;
            6'd20: a = 16'd6544;
            6'd21: a = 16'd6782;
            6'd22: a = 16'd7230;
            6'd23: a = 16'd7484;
            6'd24: a = 16'd7737;
            6'd25: a = 16'd8011;
            6'd26: a = 16'd8500;
            6'd27: a = 16'd8868;
            6'd28: a = 16'd9264;
            6'd29: a = 16'd9640;
            6'd30: a = 16'd10100;
            6'd31: a = 16'd10551;
            6'd32: a = 16'd11000;
            6'd33: a = 16'd11511;
            6'd34: a = 16'd12099;
            6'd35: a = 16'd12628;
            6'd36: a = 16'd13225;
            6'd37: a = 16'd14101;
            6'd38: a = 16'd15391;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/eli_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module eli_div #(
    parameter int DVD_W = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DVD_W-1:0]             i_dividend,
    input  logic [eli_pkg::ELI_DVS_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [DVD_W-1:0]             o_quotient
);
    import eli_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DVD_W-1:0]     r_q;
    logic [ELI_DVS_W-1:0] r_rem;
    logic [ELI_DVS_W-1:0] r_dvs;

    logic [ELI_DVS_W:0]   rem_sh;
    logic [ELI_DVS_W:0]   trial;
    logic                 ge;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        trial  = rem_sh - {1'b0, r_dvs};
    end

    // Control: iteration count and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1)) && !i_start;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: shift quotient bits in as dividend bits go out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= ge ? trial[ELI_DVS_W-1:0] : rem_sh[ELI_DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/encoder_length_interpolator.sv
// Top level: encoder count accumulator and table length interpolator.
// With enable clear an accepted item goes straight to the result register. With enable set,
// an angle outside the table takes one serial divider pass (the gear division); an angle in
// segment k takes two passes of the DVD_W-bit (32 at defaults) divider and a scan up to k.
// Items are handled one at a time; a new one is accepted the cycle after the previous result loads.
// Reset (synchronous, active low) clears totals, length and handshakes; gear divisor = 70.
`timescale 1ns / 1ps

module encoder_length_interpolator #(
    parameter int TABLE_POINTS = eli_pkg::ELI_POINTS_DEF,
    parameter int SEGMENT_STEP = eli_pkg::ELI_STEP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // [15:0] encoder_reading
    input  logic [1:0]                    s_axis_tuser,  // [0] enable, [1] calibrate_zero
    // Result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,  // [15:0] length_position,
                                                         // [47:16] accumulated_count
    output logic [0:0]                    m_axis_tuser,  // [0] computed
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eli_pkg::ELI_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import eli_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_POINTS);
    localparam int STEP_W = $clog2(SEGMENT_STEP + 1);
    localparam int LEN_W  = STEP_W + IDX_W;
    localparam int NUM_W  = STEP_W + 18;
    localparam int DVD_A  = (NUM_W > 32) ? NUM_W : 32;
    localparam int DVD_W  = (DVD_A > LEN_W + 2) ? DVD_A : LEN_W + 2;

    // Reciprocal of 5 for the 4/5 scaling, exact over the whole length range
    localparam int SCL_W  = LEN_W + 2;
    localparam int SCL_SH = SCL_W + 2;
    localparam int PROD_W = LEN_W + SCL_W;
    localparam logic [SCL_W-1:0] SCL_M =
        SCL_W'(((longint'(1) << SCL_SH) + longint'(4)) / longint'(5));

    localparam logic [NUM_W-1:0] STEP_N   = NUM_W'(SEGMENT_STEP);
    localparam logic [LEN_W-1:0] STEP_L   = LEN_W'(SEGMENT_STEP);
    localparam logic [LEN_W-1:0] LEN_TOP  = LEN_W'((TABLE_POINTS - 1) * SEGMENT_STEP);
    localparam logic [15:0]      ANG_LAST = eli_angle(6'(TABLE_POINTS - 1));
    localparam logic [15:0]      ANG_FIRST = eli_angle(6'd0);

    t_eli_state r_state, n_state;

    logic [7:0]       r_gear;
    logic [15:0]      r_prev;
    logic [31:0]      r_total;
    logic [15:0]      r_last;
    logic             r_comp;
    logic             r_neg;
    logic [15:0]      r_angle;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_diff;
    logic [15:0]      r_span;
    logic [LEN_W-1:0] r_len;

    logic             r_o_valid;
    logic [15:0]      r_o_len;
    logic [31:0]      r_o_cnt;
    logic             r_o_comp;

    logic             in_acc;
    logic             out_load;
    logic [15:0]      delta16;
    logic [31:0]      sum_total;
    logic [15:0]      ang_cur;
    logic [15:0]      ang_prv;
    logic [15:0]      q16;
    logic [LEN_W-1:0] base;
    logic [DVD_W-1:0] base_x;
    logic [NUM_W-1:0] seg_num;
    logic [ELI_DVS_W-1:0] seg_den;
    logic [PROD_W-1:0] scl_prod;
    logic [LEN_W-1:0]  scl_len;

    logic                 div_start;
    logic [DVD_W-1:0]     div_dvd;
    logic [ELI_DVS_W-1:0] div_dvs;
    logic                 div_done;
    logic [DVD_W-1:0]     div_quot;

    eli_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Configuration register access
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr == ELI_ADDR_GEAR) begin
            prdata = {24'd0, r_gear};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear <= ELI_GEAR_RST;
        end else if (psel && penable && pwrite && pready && (paddr == ELI_ADDR_GEAR)) begin
            r_gear <= pwdata[7:0];
        end
    end

    // Handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_DONE) && (!r_o_valid || m_axis_tready);

    // Count update and per-step datapath terms
    always_comb begin
        delta16   = s_axis_tdata - r_prev;
        sum_total = r_total + {{16{delta16[15]}}, delta16};
        ang_cur   = eli_angle(6'(r_idx));
        ang_prv   = eli_angle(6'(r_idx - IDX_W'(1)));
        q16       = r_neg ? (16'd0 - div_quot[15:0]) : div_quot[15:0];
        base      = LEN_W'(r_idx) * STEP_L;
        base_x    = DVD_W'(base);
        seg_num   = ((STEP_N * NUM_W'(r_diff)) << 1) + NUM_W'(r_span);
        seg_den   = (r_span == 16'd0) ? ELI_DVS_W'(2) : ELI_DVS_W'({r_span, 1'b0});
    end

    // Scale the length by 4/5 with a reciprocal multiply
    always_comb begin
        scl_prod = PROD_W'(r_len) * PROD_W'(SCL_M);
        scl_len  = scl_prod[SCL_W +: LEN_W];
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and divider requests
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = s_axis_tuser[0] ? ST_GDIV0 : ST_DONE;
                end
            end
            ST_GDIV0: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(r_neg ? (32'd0 - r_total) : r_total);
                div_dvs   = (r_gear == 8'd0) ? ELI_DVS_W'(1) : ELI_DVS_W'(r_gear);
                n_state   = ST_GDIV;
            end
            ST_GDIV: begin
                if (div_done) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_angle < ANG_FIRST || r_angle >= ANG_LAST) begin
                    n_state = ST_SCL;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_angle < ang_cur) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(seg_num);
                div_dvs   = seg_den;
                n_state   = ST_SDIV;
            end
            ST_SDIV: begin
                if (div_done) begin
                    n_state = ST_SCL;
                end
            end
            ST_SCL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Architectural state: previous reading, total, last length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_total <= '0;
            r_last  <= '0;
        end else begin
            if (in_acc) begin
                r_prev <= s_axis_tdata;
                if (s_axis_tuser[0]) begin
                    r_total <= s_axis_tuser[1] ? 32'd0 : sum_total;
                end
            end
            if (r_state == ST_SCL) begin
                r_last <= 16'(scl_len);
            end
        end
    end

    // Working registers of the current item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_comp <= s_axis_tuser[0];
            r_neg  <= s_axis_tuser[1] ? 1'b0 : sum_total[31];
        end
        case (r_state)
            ST_GDIV: begin
                if (div_done) begin
                    r_angle <= q16;
                    r_idx   <= IDX_W'(1);
                end
            end
            ST_CHK: begin
                // below the first point gives zero, at or past the last the top length
                r_len <= (r_angle < ANG_FIRST) ? '0 : LEN_TOP;
            end
            ST_SCAN: begin
                if (r_angle < ang_cur) begin
                    r_diff <= ang_cur - r_angle;
                    r_span <= ang_cur - ang_prv;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            ST_SDIV: begin
                if (div_done) begin
                    r_len <= (div_quot <= base_x) ? LEN_W'(base_x - div_quot) : '0;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_len  <= r_last;
            r_o_cnt  <= r_total;
            r_o_comp <= r_comp;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_cnt, r_o_len};
    assign m_axis_tuser  = r_o_comp;

endmodule
